/* src/tsd_pkg.sv */
// tsd_pkg: widths, codes, request type and helper functions of the touch swipe detector
// no dependencies; used by the channel interfaces and every module of the block
`timescale 1ns / 1ps

package tsd_pkg;

    // design parameters
    localparam int RAW_BITS    = 16;
    localparam int SCREEN_BITS = 12;

    // field and register widths
    localparam int EVT_W      = 16;
    localparam int RAW_W      = (RAW_BITS < EVT_W) ? RAW_BITS : EVT_W;
    localparam int CMD_W      = 3;
    localparam int DIR_W      = 3;
    localparam int SCR_REG_W  = 13;
    localparam int RAWCFG_W   = 16;
    localparam int MIN_W      = 12;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    // datapath widths
    localparam int MAG_W  = RAWCFG_W;
    localparam int PROD_W = MAG_W + SCR_REG_W;
    localparam int LIM_W  = SCREEN_BITS + 1;
    localparam int POS_W  = SCREEN_BITS + 1;
    localparam int CMP_W  = (SCREEN_BITS + 3 > MIN_W) ? SCREEN_BITS + 3 : MIN_W;
    localparam int CAP    = 1 << SCREEN_BITS;

    // touch key value meaning press
    localparam logic [EVT_W-1:0] KEY_PRESS = EVT_W'(1);

    // reset values of the registers
    localparam logic [SCR_REG_W-1:0] RST_SCREEN_W = SCR_REG_W'(800);
    localparam logic [SCR_REG_W-1:0] RST_SCREEN_H = SCR_REG_W'(480);
    localparam logic [RAWCFG_W-1:0]  RST_RAW_W    = RAWCFG_W'(1024);
    localparam logic [RAWCFG_W-1:0]  RST_RAW_H    = RAWCFG_W'(600);
    localparam logic [RAWCFG_W-1:0]  RST_RAW_OFF  = RAWCFG_W'(0);
    localparam logic [MIN_W-1:0]     RST_MIN      = MIN_W'(50);

    typedef enum logic [CMD_W-1:0] {
        CMD_ABS_X = 3'd0,
        CMD_ABS_Y = 3'd1,
        CMD_KEY   = 3'd2,
        CMD_SYNC  = 3'd3,
        CMD_OTHER = 3'd4
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_W  = 3'd0,
        CFG_SCREEN_H  = 3'd1,
        CFG_RAW_W     = 3'd2,
        CFG_RAW_H     = 3'd3,
        CFG_RAW_Y_OFF = 3'd4,
        CFG_MIN_SWIPE = 3'd5
    } t_cfg_idx;

    typedef enum logic [DIR_W-1:0] {
        DIR_NONE  = 3'd0,
        DIR_UP    = 3'd1,
        DIR_DOWN  = 3'd2,
        DIR_LEFT  = 3'd3,
        DIR_RIGHT = 3'd4
    } t_dir;

    // one axis scaling job: q = num * mul / div, clamped to [0, limit-1]
    typedef struct packed {
        logic                 force_zero;
        logic [MAG_W-1:0]     num_mag;
        logic [SCR_REG_W-1:0] mul;
        logic [MAG_W-1:0]     div_mag;
        logic [LIM_W-1:0]     limit;
    } t_scale_req;

    // screen dimension saturated at the output range
    function automatic logic [LIM_W-1:0] f_limit(input logic [SCR_REG_W-1:0] dim);
        if (32'(dim) > CAP) begin
            f_limit = LIM_W'(CAP);
        end else begin
            f_limit = LIM_W'(dim);
        end
    endfunction

endpackage

/* src/tsd_in_if.sv */
// tsd_in_if: touch event channel, valid/ready with command and raw value
// depends on tsd_pkg
`timescale 1ns / 1ps

interface tsd_in_if;
    import tsd_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [EVT_W-1:0] event_value;

    modport source (output valid, output cmd, output event_value, input ready);
    modport sink   (input valid, input cmd, input event_value, output ready);
endinterface

/* src/tsd_out_if.sv */
// tsd_out_if: swipe result channel, valid/ready with direction and end point
// depends on tsd_pkg
`timescale 1ns / 1ps

interface tsd_out_if;
    import tsd_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [DIR_W-1:0]       direction;
    logic [SCREEN_BITS-1:0] end_x;
    logic [SCREEN_BITS-1:0] end_y;

    modport source (output valid, output direction, output end_x, output end_y,
                    input ready);
    modport sink   (input valid, input direction, input end_x, input end_y,
                    output ready);
endinterface

/* src/tsd_scale.sv */
// tsd_scale: one axis scaler, bit-serial shift-add multiply then restoring divide
// depends on tsd_pkg
`timescale 1ns / 1ps

module tsd_scale (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  tsd_pkg::t_scale_req            i_req,
    output logic                           o_done,
    output logic [tsd_pkg::SCREEN_BITS-1:0] o_q
);
    import tsd_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_cnt;
    t_scale_req        r_req;
    logic [PROD_W-1:0] r_p;
    logic [MAG_W-1:0]  r_rem;

    logic [MAG_W:0]    w_sum;
    logic [MAG_W:0]    w_trial;
    logic [MAG_W:0]    w_diff;
    logic              w_ge;
    logic [PROD_W-1:0] n_p_mul;
    logic [PROD_W-1:0] n_p_div;
    logic [MAG_W-1:0]  n_rem;
    logic [SCREEN_BITS-1:0] n_q;

    // multiply step: add multiplicand into the high half when the low bit is set
    always_comb begin
        w_sum = {1'b0, r_p[PROD_W-1:SCR_REG_W]} + {1'b0, r_req.num_mag};
        if (r_p[0]) begin
            n_p_mul = {w_sum, r_p[SCR_REG_W-1:1]};
        end else begin
            n_p_mul = {1'b0, r_p[PROD_W-1:1]};
        end
    end

    // divide step: shift one dividend bit into the remainder, trial subtract
    always_comb begin
        w_trial = {r_rem, r_p[PROD_W-1]};
        w_diff  = w_trial - {1'b0, r_req.div_mag};
        w_ge    = (w_trial >= {1'b0, r_req.div_mag});
        n_rem   = w_ge ? w_diff[MAG_W-1:0] : w_trial[MAG_W-1:0];
        n_p_div = {r_p[PROD_W-2:0], w_ge};
    end

    // clamp quotient to the screen
    always_comb begin
        if (r_req.force_zero) begin
            n_q = '0;
        end else if (r_p >= PROD_W'(r_req.limit)) begin
            n_q = SCREEN_BITS'(r_req.limit - LIM_W'(1));
        end else begin
            n_q = r_p[SCREEN_BITS-1:0];
        end
    end

    // sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_req   <= i_req;
                        r_p     <= {{MAG_W{1'b0}}, i_req.mul};
                        r_cnt   <= CNT_W'(SCR_REG_W - 1);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_p <= n_p_mul;
                    if (r_cnt == '0) begin
                        r_cnt   <= CNT_W'(PROD_W - 1);
                        r_rem   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_DIV: begin
                    r_p   <= n_p_div;
                    r_rem <= n_rem;
                    if (r_cnt == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                S_FIN: begin
                    o_q     <= n_q;
                    o_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

/* src/tsd_classify.sv */
// tsd_classify: swipe direction from start and end points and the minimum distance
// depends on tsd_pkg
`timescale 1ns / 1ps

module tsd_classify (
    input  logic signed [tsd_pkg::POS_W-1:0]       i_start_x,
    input  logic signed [tsd_pkg::POS_W-1:0]       i_start_y,
    input  logic        [tsd_pkg::SCREEN_BITS-1:0] i_end_x,
    input  logic        [tsd_pkg::SCREEN_BITS-1:0] i_end_y,
    input  logic        [tsd_pkg::MIN_W-1:0]       i_min,
    output tsd_pkg::t_dir                          o_dir
);
    import tsd_pkg::*;

    logic signed [CMP_W-1:0] w_dx;
    logic signed [CMP_W-1:0] w_dy;
    logic        [CMP_W-1:0] w_ax;
    logic        [CMP_W-1:0] w_ay;
    logic        [CMP_W-1:0] w_min;
    logic                    w_dx_pos;
    logic                    w_dy_pos;

    // displacements and their magnitudes
    always_comb begin
        w_dx     = $signed(CMP_W'(i_end_x)) - CMP_W'(i_start_x);
        w_dy     = $signed(CMP_W'(i_end_y)) - CMP_W'(i_start_y);
        w_ax     = w_dx[CMP_W-1] ? CMP_W'(-w_dx) : CMP_W'(w_dx);
        w_ay     = w_dy[CMP_W-1] ? CMP_W'(-w_dy) : CMP_W'(w_dy);
        w_min    = CMP_W'(i_min);
        w_dx_pos = !w_dx[CMP_W-1] && (w_dx != '0);
        w_dy_pos = !w_dy[CMP_W-1] && (w_dy != '0);
    end

    // dominant axis decides the direction
    always_comb begin
        if (w_ax < w_min && w_ay < w_min) begin
            o_dir = DIR_NONE;
        end else if (w_ax > {w_ay[CMP_W-2:0], 1'b0}) begin
            o_dir = w_dx_pos ? DIR_RIGHT : DIR_LEFT;
        end else if (w_ay > {w_ax[CMP_W-2:0], 1'b0}) begin
            o_dir = w_dy_pos ? DIR_DOWN : DIR_UP;
        end else begin
            o_dir = DIR_NONE;
        end
    end
endmodule

/* src/touch_swipe_direction.sv */
// touch_swipe_direction: top level of the touch swipe detector
// depends on tsd_pkg, tsd_in_if, tsd_out_if, tsd_scale and tsd_classify
`timescale 1ns / 1ps

// Takes one touch event per transfer. Absolute X and Y events, sync reports and
// other codes are taken without leaving the idle state. A touch key event
// starts two axis scalers, X and Y side by side, each a 13-step serial multiply
// followed by a 29-step restoring divide; the event port is not ready until the
// key event is done. A release delivers one result (direction, end point)
// through an output register, so the next event is taken while that result
// waits. Start X is set back to -1 after each release. Configuration is written
// through the plain write port; the user must write it only while no event is
// in flight, which the block does not enforce; unknown indexes are ignored.
module touch_swipe_direction (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    tsd_in_if.sink                            i_evt,
    tsd_out_if.source                         o_res,
    input  logic                              i_cfg_wr_en,
    input  logic [tsd_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [tsd_pkg::CFG_DATA_W-1:0]    i_cfg_wdata
);
    import tsd_pkg::*;

    typedef enum logic [1:0] {T_IDLE, T_SCALE, T_EMIT} t_state;

    t_state                  r_state;
    logic                    r_press;
    logic [SCR_REG_W-1:0]    r_scr_w;
    logic [SCR_REG_W-1:0]    r_scr_h;
    logic [RAWCFG_W-1:0]     r_raw_w;
    logic [RAWCFG_W-1:0]     r_raw_h;
    logic [RAWCFG_W-1:0]     r_raw_off;
    logic [MIN_W-1:0]        r_min;
    logic [RAW_W-1:0]        r_raw_x;
    logic [RAW_W-1:0]        r_raw_y;
    logic signed [POS_W-1:0] r_sx;
    logic signed [POS_W-1:0] r_sy;
    logic                    r_ovalid;
    t_dir                    r_dir;
    logic [SCREEN_BITS-1:0]  r_ex;
    logic [SCREEN_BITS-1:0]  r_ey;

    logic                    w_accept;
    logic                    w_start;
    t_scale_req              w_req_x;
    t_scale_req              w_req_y;
    logic [MAG_W:0]          w_ny;
    logic [MAG_W:0]          w_ny_neg;
    logic [MAG_W:0]          w_dy;
    logic [MAG_W:0]          w_dy_neg;
    logic [LIM_W-1:0]        w_lim_x;
    logic [LIM_W-1:0]        w_lim_y;
    logic                    w_done_x;
    logic                    w_done_y;
    logic [SCREEN_BITS-1:0]  w_qx;
    logic [SCREEN_BITS-1:0]  w_qy;
    t_dir                    w_dir;

    // event channel handshake
    assign i_evt.ready = (r_state == T_IDLE);
    assign w_accept    = i_evt.valid && i_evt.ready;
    assign w_start     = w_accept && (t_cmd'(i_evt.cmd) == CMD_KEY);

    // result channel
    assign o_res.valid     = r_ovalid;
    assign o_res.direction = DIR_W'(r_dir);
    assign o_res.end_x     = r_ex;
    assign o_res.end_y     = r_ey;

    // scaling jobs built from the current raw point and configuration
    always_comb begin
        w_lim_x = f_limit(r_scr_w);
        w_lim_y = f_limit(r_scr_h);

        w_req_x.force_zero = (w_lim_x == '0) || (r_raw_w == '0);
        w_req_x.num_mag    = MAG_W'(r_raw_x);
        w_req_x.mul        = r_scr_w;
        w_req_x.div_mag    = r_raw_w;
        w_req_x.limit      = w_lim_x;

        // signed offsets: a negative quotient clamps to zero
        w_ny     = {1'b0, MAG_W'(r_raw_y)} - {1'b0, r_raw_off};
        w_ny_neg = -w_ny;
        w_dy     = {1'b0, r_raw_h} - {1'b0, r_raw_off};
        w_dy_neg = -w_dy;

        w_req_y.num_mag    = w_ny[MAG_W] ? w_ny_neg[MAG_W-1:0] : w_ny[MAG_W-1:0];
        w_req_y.div_mag    = w_dy[MAG_W] ? w_dy_neg[MAG_W-1:0] : w_dy[MAG_W-1:0];
        w_req_y.force_zero = (w_lim_y == '0) || (w_dy == '0) ||
                             (w_ny[MAG_W] ^ w_dy[MAG_W]);
        w_req_y.mul        = r_scr_h;
        w_req_y.limit      = w_lim_y;
    end

    tsd_scale u_scale_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_req   (w_req_x),
        .o_done  (w_done_x),
        .o_q     (w_qx)
    );

    tsd_scale u_scale_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_req   (w_req_y),
        .o_done  (w_done_y),
        .o_q     (w_qy)
    );

    tsd_classify u_classify (
        .i_start_x (r_sx),
        .i_start_y (r_sy),
        .i_end_x   (w_qx),
        .i_end_y   (w_qy),
        .i_min     (r_min),
        .o_dir     (w_dir)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w   <= RST_SCREEN_W;
            r_scr_h   <= RST_SCREEN_H;
            r_raw_w   <= RST_RAW_W;
            r_raw_h   <= RST_RAW_H;
            r_raw_off <= RST_RAW_OFF;
            r_min     <= RST_MIN;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_SCREEN_W:  r_scr_w   <= i_cfg_wdata[SCR_REG_W-1:0];
                CFG_SCREEN_H:  r_scr_h   <= i_cfg_wdata[SCR_REG_W-1:0];
                CFG_RAW_W:     r_raw_w   <= i_cfg_wdata[RAWCFG_W-1:0];
                CFG_RAW_H:     r_raw_h   <= i_cfg_wdata[RAWCFG_W-1:0];
                CFG_RAW_Y_OFF: r_raw_off <= i_cfg_wdata[RAWCFG_W-1:0];
                CFG_MIN_SWIPE: r_min     <= i_cfg_wdata[MIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // event sequencer, touch state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= T_IDLE;
            r_ovalid <= 1'b0;
            r_press  <= 1'b0;
            r_raw_x  <= '0;
            r_raw_y  <= '0;
            r_sx     <= '1;
            r_sy     <= '1;
        end else begin
            // a taken result frees the register unless the emit state reloads it
            if (o_res.ready && (r_state != T_EMIT)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                T_IDLE: begin
                    if (w_accept) begin
                        case (t_cmd'(i_evt.cmd))
                            CMD_ABS_X: r_raw_x <= i_evt.event_value[RAW_W-1:0];
                            CMD_ABS_Y: r_raw_y <= i_evt.event_value[RAW_W-1:0];
                            CMD_KEY: begin
                                r_press <= (i_evt.event_value == KEY_PRESS);
                                r_state <= T_SCALE;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                T_SCALE: begin
                    if (w_done_x && w_done_y) begin
                        if (r_press) begin
                            r_sx    <= POS_W'(w_qx);
                            r_sy    <= POS_W'(w_qy);
                            r_state <= T_IDLE;
                        end else begin
                            r_state <= T_EMIT;
                        end
                    end
                end
                T_EMIT: begin
                    // wait for the result register to free up
                    if (!r_ovalid || o_res.ready) begin
                        r_ovalid <= 1'b1;
                        r_dir    <= w_dir;
                        r_ex     <= w_qx;
                        r_ey     <= w_qy;
                        r_sx     <= '1;
                        r_state  <= T_IDLE;
                    end
                end
                default: begin
                    r_state <= T_IDLE;
                end
            endcase
        end
    end
endmodule
